FILE: design/scs_pkg.sv
package scs_pkg;

    // Field widths
    localparam int SAMPLE_W    = 24;
    localparam int CTRL_W      = 16;
    localparam int COEF_W      = 16;
    localparam int CFG_IDX_W   = 4;

    // Width stage output: |L1| < 2.44 * 2^24 fits 27 bits signed
    localparam int WIDE_W      = 27;
    // After pan and optional negation
    localparam int PANNED_W    = WIDE_W + 1;

    // Default table resolution (quarter wave)
    localparam int PAN_TABLE_SIZE_DEF = 256;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_GAIN   = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PAN    = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_INVERT = 4'd3;

    // Reset values
    localparam logic [CTRL_W-1:0] GAIN_RST  = 16'd4096;
    localparam logic [CTRL_W-1:0] WIDTH_RST = 16'd16384;

    // Settings seen by the datapath
    typedef struct packed {
        logic [CTRL_W-1:0] gain;
        logic [CTRL_W-1:0] width;
        logic              invert;
        logic [COEF_W-1:0] cos_coef;
        logic [COEF_W-1:0] sin_coef;
    } cfg_t;

endpackage

FILE: design/scs_cfg.sv
module scs_cfg
    import scs_pkg::*;
#(
    parameter int PAN_TABLE_SIZE = PAN_TABLE_SIZE_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CTRL_W-1:0]    cfg_data,
    output cfg_t                 cfg
);

    localparam int    IDX_W   = $clog2(PAN_TABLE_SIZE + 1);
    localparam int    SCALE_W = CTRL_W + IDX_W + 1;
    localparam longint PI_Q30  = 64'sd3373259426;
    localparam longint TAB_DEN = 2 * PAN_TABLE_SIZE;

    // sin(k*pi/(2N)) in Q1.15 by a Q2.30 Taylor series, evaluated at elaboration
    function automatic longint taylor_pow2(longint term, longint x);
        longint t;
        t = (term * x) >>> 30;
        return (t * x) >>> 30;
    endfunction

    function automatic logic [COEF_W-1:0] sine_entry(int k);
        longint x;
        longint term;
        longint sum;
        longint q;
        x    = longint'(k) * PI_Q30 / TAB_DEN;
        sum  = x;
        term = taylor_pow2(x, x) / 6;      sum = sum - term;
        term = taylor_pow2(term, x) / 20;  sum = sum + term;
        term = taylor_pow2(term, x) / 42;  sum = sum - term;
        term = taylor_pow2(term, x) / 72;  sum = sum + term;
        term = taylor_pow2(term, x) / 110; sum = sum - term;
        term = taylor_pow2(term, x) / 156; sum = sum + term;
        term = taylor_pow2(term, x) / 210; sum = sum - term;
        term = taylor_pow2(term, x) / 272; sum = sum + term;
        term = taylor_pow2(term, x) / 342; sum = sum - term;
        if (sum < 0)
        begin
            sum = 0;
        end
        q = (sum + 64'sd16384) >>> 15;
        if (q > 64'sd32768)
        begin
            q = 64'sd32768;
        end
        return q[COEF_W-1:0];
    endfunction

    logic [COEF_W-1:0] sine_tab [0:PAN_TABLE_SIZE];

    for (genvar k = 0; k <= PAN_TABLE_SIZE; k++)
    begin : g_tab
        assign sine_tab[k] = sine_entry(k);
    end

    logic [CTRL_W-1:0]        gain_reg;
    logic signed [CTRL_W-1:0] pan_reg;
    logic [CTRL_W-1:0]        width_reg;
    logic                     invert_reg;
    logic [IDX_W-1:0]         idx_reg;
    logic [IDX_W-1:0]         idx_next;
    logic [COEF_W-1:0]        cos_reg;
    logic [COEF_W-1:0]        sin_reg;
    logic [CTRL_W-1:0]        offs;
    logic [SCALE_W-1:0]       scaled;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg   <= GAIN_RST;
            pan_reg    <= '0;
            width_reg  <= WIDTH_RST;
            invert_reg <= 1'b0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_GAIN:   gain_reg   <= cfg_data;
                REG_PAN:    pan_reg    <= cfg_data;
                REG_WIDTH:  width_reg  <= cfg_data;
                REG_INVERT: invert_reg <= cfg_data[0];
                default:    ;
            endcase
        end
    end

    // Pan clamped to full left/right, shifted to 0..32768
    always_comb
    begin
        if (pan_reg < -16'sd16384)
        begin
            offs = '0;
        end
        else if (pan_reg > 16'sd16384)
        begin
            offs = 16'd32768;
        end
        else
        begin
            offs = pan_reg + 16'd16384;
        end
        scaled   = SCALE_W'(offs) * SCALE_W'(PAN_TABLE_SIZE) + SCALE_W'(16384);
        idx_next = IDX_W'(scaled >> 15);
    end

    // Coefficients follow the pan register through idx_reg and then cos_reg/sin_reg
    always_ff @(posedge clk)
    begin
        idx_reg <= idx_next;
        cos_reg <= sine_tab[IDX_W'(PAN_TABLE_SIZE) - idx_reg];
        sin_reg <= sine_tab[idx_reg];
    end

    assign cfg.gain     = gain_reg;
    assign cfg.width    = width_reg;
    assign cfg.invert   = invert_reg;
    assign cfg.cos_coef = cos_reg;
    assign cfg.sin_coef = sin_reg;

endmodule

FILE: design/scs_width.sv
module scs_width
    import scs_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       take,
    input  logic signed [SAMPLE_W-1:0] sample_left,
    input  logic signed [SAMPLE_W-1:0] sample_right,
    input  logic                       right_present,
    input  logic [CTRL_W-1:0]          width,
    output logic                       wide_valid,
    output logic signed [WIDE_W-1:0]   wide_left,
    output logic signed [WIDE_W-1:0]   wide_right
);

    localparam int SUM_W  = SAMPLE_W + 1;
    localparam int PROD_W = SUM_W + CTRL_W + 1;
    localparam int ACC_W  = PROD_W + 2;

    logic                       in_valid_reg;
    logic signed [SAMPLE_W-1:0] sl_reg;
    logic signed [SAMPLE_W-1:0] sr_reg;
    logic                       mul_valid_reg;
    logic signed [SUM_W-1:0]    sum_reg;
    logic signed [SUM_W-1:0]    sum_next;
    logic signed [SUM_W-1:0]    diff_next;
    logic signed [PROD_W-1:0]   prod_reg;
    logic signed [PROD_W-1:0]   prod_next;
    logic signed [ACC_W-1:0]    mid_ext;
    logic signed [ACC_W-1:0]    prod_ext;
    logic signed [ACC_W-1:0]    lacc;
    logic signed [ACC_W-1:0]    racc;
    logic                       out_valid_reg;
    logic signed [WIDE_W-1:0]   l_reg;
    logic signed [WIDE_W-1:0]   r_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            mul_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= take;
            mul_valid_reg <= in_valid_reg;
            out_valid_reg <= mul_valid_reg;
        end
    end

    // Input capture, mono copies left into right
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            sl_reg <= sample_left;
            sr_reg <= right_present ? sample_right : sample_left;
        end
    end

    // Side times width
    always_comb
    begin
        sum_next  = {sl_reg[SAMPLE_W-1], sl_reg} + {sr_reg[SAMPLE_W-1], sr_reg};
        diff_next = {sr_reg[SAMPLE_W-1], sr_reg} - {sl_reg[SAMPLE_W-1], sl_reg};
        prod_next = diff_next * $signed({1'b0, width});
    end

    always_ff @(posedge clk)
    begin
        sum_reg  <= sum_next;
        prod_reg <= prod_next;
    end

    // mid*16384 -/+ side*w, round half up, /32768
    always_comb
    begin
        mid_ext  = {{(ACC_W-SUM_W-14){sum_reg[SUM_W-1]}}, sum_reg, 14'b0};
        prod_ext = {{(ACC_W-PROD_W){prod_reg[PROD_W-1]}}, prod_reg};
        lacc     = mid_ext - prod_ext + ACC_W'(16384);
        racc     = mid_ext + prod_ext + ACC_W'(16384);
    end

    always_ff @(posedge clk)
    begin
        l_reg <= lacc[WIDE_W+14:15];
        r_reg <= racc[WIDE_W+14:15];
    end

    assign wide_valid = out_valid_reg;
    assign wide_left  = l_reg;
    assign wide_right = r_reg;

endmodule

FILE: design/scs_pan.sv
module scs_pan
    import scs_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  cfg_t                       cfg,
    input  logic                       wide_valid,
    input  logic signed [WIDE_W-1:0]   wide_left,
    input  logic signed [WIDE_W-1:0]   wide_right,
    output logic                       pan_valid,
    output logic signed [PANNED_W-1:0] pan_left,
    output logic signed [PANNED_W-1:0] pan_right
);

    localparam int PROD_W = WIDE_W + COEF_W + 1;
    localparam int ACC_W  = PROD_W + 1;

    logic                       mul_valid_reg;
    logic                       out_valid_reg;
    logic signed [PROD_W-1:0]   pl_reg;
    logic signed [PROD_W-1:0]   pr_reg;
    logic signed [ACC_W-1:0]    lacc;
    logic signed [ACC_W-1:0]    racc;
    logic signed [PANNED_W-1:0] l2;
    logic signed [PANNED_W-1:0] r2;
    logic signed [PANNED_W-1:0] l_reg;
    logic signed [PANNED_W-1:0] r_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mul_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            mul_valid_reg <= wide_valid;
            out_valid_reg <= mul_valid_reg;
        end
    end

    // Left by cos, right by sin
    always_ff @(posedge clk)
    begin
        pl_reg <= wide_left  * $signed({1'b0, cfg.cos_coef});
        pr_reg <= wide_right * $signed({1'b0, cfg.sin_coef});
    end

    // Round /32768, then optional polarity flip
    always_comb
    begin
        lacc = {pl_reg[PROD_W-1], pl_reg} + ACC_W'(16384);
        racc = {pr_reg[PROD_W-1], pr_reg} + ACC_W'(16384);
        l2   = {lacc[WIDE_W+14], lacc[WIDE_W+14:15]};
        r2   = {racc[WIDE_W+14], racc[WIDE_W+14:15]};
    end

    always_ff @(posedge clk)
    begin
        l_reg <= cfg.invert ? -l2 : l2;
        r_reg <= cfg.invert ? -r2 : r2;
    end

    assign pan_valid = out_valid_reg;
    assign pan_left  = l_reg;
    assign pan_right = r_reg;

endmodule

FILE: design/scs_gain.sv
module scs_gain
    import scs_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic [CTRL_W-1:0]          gain,
    input  logic                       pan_valid,
    input  logic signed [PANNED_W-1:0] pan_left,
    input  logic signed [PANNED_W-1:0] pan_right,
    output logic                       out_valid,
    output logic signed [SAMPLE_W-1:0] out_left,
    output logic signed [SAMPLE_W-1:0] out_right,
    output logic                       clipped
);

    localparam int PROD_W = PANNED_W + CTRL_W + 1;
    localparam int ACC_W  = PROD_W + 1;
    localparam int RES_W  = ACC_W - 12;

    localparam logic signed [RES_W-1:0] RES_MAX = RES_W'((1 << (SAMPLE_W-1)) - 1);
    localparam logic signed [RES_W-1:0] RES_MIN = -RES_W'(1 << (SAMPLE_W-1));

    logic                       mul_valid_reg;
    logic                       out_valid_reg;
    logic signed [PROD_W-1:0]   pl_reg;
    logic signed [PROD_W-1:0]   pr_reg;
    logic signed [ACC_W-1:0]    lacc;
    logic signed [ACC_W-1:0]    racc;
    logic signed [RES_W-1:0]    lv;
    logic signed [RES_W-1:0]    rv;
    logic signed [SAMPLE_W-1:0] l_next;
    logic signed [SAMPLE_W-1:0] r_next;
    logic                       clip_next;
    logic signed [SAMPLE_W-1:0] l_reg;
    logic signed [SAMPLE_W-1:0] r_reg;
    logic                       clip_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mul_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            mul_valid_reg <= pan_valid;
            out_valid_reg <= mul_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        pl_reg <= pan_left  * $signed({1'b0, gain});
        pr_reg <= pan_right * $signed({1'b0, gain});
    end

    // Round /4096 and saturate to 24 bits
    always_comb
    begin
        lacc      = {pl_reg[PROD_W-1], pl_reg} + ACC_W'(2048);
        racc      = {pr_reg[PROD_W-1], pr_reg} + ACC_W'(2048);
        lv        = lacc[ACC_W-1:12];
        rv        = racc[ACC_W-1:12];
        clip_next = 1'b0;
        if (lv > RES_MAX)
        begin
            l_next    = RES_MAX[SAMPLE_W-1:0];
            clip_next = 1'b1;
        end
        else if (lv < RES_MIN)
        begin
            l_next    = RES_MIN[SAMPLE_W-1:0];
            clip_next = 1'b1;
        end
        else
        begin
            l_next = lv[SAMPLE_W-1:0];
        end
        if (rv > RES_MAX)
        begin
            r_next    = RES_MAX[SAMPLE_W-1:0];
            clip_next = 1'b1;
        end
        else if (rv < RES_MIN)
        begin
            r_next    = RES_MIN[SAMPLE_W-1:0];
            clip_next = 1'b1;
        end
        else
        begin
            r_next = rv[SAMPLE_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        l_reg    <= l_next;
        r_reg    <= r_next;
        clip_reg <= clip_next;
    end

    assign out_valid = out_valid_reg;
    assign out_left  = l_reg;
    assign out_right = r_reg;
    assign clipped   = clip_reg;

endmodule

FILE: design/stereo_channel_strip.sv
// Stereo channel strip: mid/side width, equal-power pan, phase invert and gain
// on one Q1.23 sample pair. A pair is taken on every clock where start is high
// (busy never rises) and its result appears on out_left/out_right/clipped with
// out_valid high for exactly one cycle. The pair passes through the seven-register
// datapath (capture, width multiply, width round, pan multiply, pan round and
// invert, gain multiply, gain round and saturate), and one pair per cycle
// streams through it. There is no output buffering and the receiver cannot
// stall: a result not taken in its strobe cycle is gone. Settings are written
// through the cfg_* channel, which is always ready; write them only while no
// pair is in flight. A pan write reaches the sine/cosine coefficients through
// idx_reg and then cos_reg/sin_reg, in time for the pan multiply of a pair
// taken with or after it.
module stereo_channel_strip
    import scs_pkg::*;
#(
    parameter int PAN_TABLE_SIZE = PAN_TABLE_SIZE_DEF
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    // sample pair in
    input  logic                       start,
    output logic                       busy,
    input  logic signed [SAMPLE_W-1:0] sample_left,
    input  logic signed [SAMPLE_W-1:0] sample_right,
    input  logic                       right_present,
    // settings write channel
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [CFG_IDX_W-1:0]       cfg_index,
    input  logic [CTRL_W-1:0]          cfg_data,
    // result out
    output logic                       out_valid,
    output logic signed [SAMPLE_W-1:0] out_left,
    output logic signed [SAMPLE_W-1:0] out_right,
    output logic                       clipped
);

    cfg_t                       cfg;
    logic                       take;
    logic                       wide_valid;
    logic signed [WIDE_W-1:0]   wide_left;
    logic signed [WIDE_W-1:0]   wide_right;
    logic                       pan_valid;
    logic signed [PANNED_W-1:0] pan_left;
    logic signed [PANNED_W-1:0] pan_right;

    // Fully pipelined, nothing to hold off on either channel
    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;
    assign take      = start & ~busy;

    // Settings registers plus pan coefficient lookup
    scs_cfg #(
        .PAN_TABLE_SIZE (PAN_TABLE_SIZE)
    ) u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid & cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Capture, mono fold and mid/side width
    scs_width u_width (
        .clk           (clk),
        .rst_n         (rst_n),
        .take          (take),
        .sample_left   (sample_left),
        .sample_right  (sample_right),
        .right_present (right_present),
        .width         (cfg.width),
        .wide_valid    (wide_valid),
        .wide_left     (wide_left),
        .wide_right    (wide_right)
    );

    // Equal-power pan and polarity
    scs_pan u_pan (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .wide_valid (wide_valid),
        .wide_left  (wide_left),
        .wide_right (wide_right),
        .pan_valid  (pan_valid),
        .pan_left   (pan_left),
        .pan_right  (pan_right)
    );

    // Linear gain and output saturation
    scs_gain u_gain (
        .clk       (clk),
        .rst_n     (rst_n),
        .gain      (cfg.gain),
        .pan_valid (pan_valid),
        .pan_left  (pan_left),
        .pan_right (pan_right),
        .out_valid (out_valid),
        .out_left  (out_left),
        .out_right (out_right),
        .clipped   (clipped)
    );

endmodule
